FILE: src/dqns_pkg.sv
// ----------------------------------------------------------------------------
// dqns_pkg
// shared types and constants for the dns query name sniffer
// ----------------------------------------------------------------------------
`default_nettype none

package dqns_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [15:0] DNS_PORT       = 16'd53;
    localparam logic [3:0]  IHL_MIN        = 4'd5;
    localparam logic [7:0]  DNS_FLAGS_MASK = 8'hFB;
    localparam logic [7:0]  DNS_FLAGS_WANT = 8'h01;
    localparam logic [15:0] QDCOUNT_ONE    = 16'd1;
    localparam logic [7:0]  CHAR_DOT       = 8'h2E;

    // private ranges as fixed prefixes
    localparam logic [7:0]  PRIV_A_PREFIX  = 8'h0A;
    localparam logic [11:0] PRIV_B_PREFIX  = 12'hAC1;
    localparam logic [15:0] PRIV_C_PREFIX  = 16'hC0A8;

    // queue entry kinds
    typedef enum logic [0:0] {
        KIND_START = 1'b0,
        KIND_BYTE  = 1'b1
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        logic        last;
        logic [7:0]  data;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } queue_entry_t;

endpackage

`default_nettype wire

FILE: src/dns_query_name_sniffer.sv
// ----------------------------------------------------------------------------
// dns_query_name_sniffer
// extracts the query name of plain dns queries from a byte-wide frame stream
// ----------------------------------------------------------------------------
// the byte that causes a result request is written to the queue, then popped into the output register
// throughput: one frame byte per cycle, set by the header parser which takes
//   a byte whenever the four-entry queue has room
// one result per byte at most, so the name decoder keeps pace with the input
// reset: aresetn low at a clock edge clears the parser, queue, name decoder state and output valid register
// ----------------------------------------------------------------------------
`default_nettype none

module dns_query_name_sniffer import dqns_pkg::*; #(
    parameter int MAX_NAME_CHARS = 512
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // frame byte stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tlast,   // frame_end
    // name character stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata,   // [7:0] name_char, [39:8] source_address,
                                              // [71:40] dest_address
    output logic              m_axis_tlast,   // name_done
    output logic [1:0]        m_axis_tuser    // [0] name_overflow, [1] name_truncated
);

    // parser to queue
    logic         push;
    queue_entry_t push_entry;
    logic         queue_full;

    // queue to name decoder
    logic         pop;
    queue_entry_t pop_entry;
    logic         queue_empty;

    logic [7:0]   name_char;
    logic         name_overflow, name_truncated;
    logic [31:0]  source_address, dest_address;

    // front: header fields and qualification, one byte a cycle while the queue has room
    dqns_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_data    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .queue_full (queue_full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    // short queue so parser and decoder stall independently
    dqns_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    // back: label walk and the output register
    dqns_name #(
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_name (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .entry         (pop_entry),
        .entry_valid   (!queue_empty),
        .entry_pop     (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_char      (name_char),
        .out_done      (m_axis_tlast),
        .out_overflow  (name_overflow),
        .out_truncated (name_truncated),
        .out_src       (source_address),
        .out_dst       (dest_address)
    );

    assign m_axis_tdata = {dest_address, source_address, name_char};
    assign m_axis_tuser = {name_truncated, name_overflow};

endmodule

`default_nettype wire

FILE: src/dqns_parse.sv
// ----------------------------------------------------------------------------
// dqns_parse
// header parser: tracks ethernet, ipv4, udp and dns header fields and queues a start
// entry and every later byte (query name onward) of a qualifying frame
// ----------------------------------------------------------------------------
`default_nettype none

module dqns_parse import dqns_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  wire logic [7:0]   in_data,
    input  wire logic         in_last,
    input  wire logic         queue_full,
    output logic              in_ready,
    output logic              push,
    output queue_entry_t      push_entry
);

    typedef enum logic [2:0] {
        PH_ETH, PH_IP, PH_UDP, PH_DNS, PH_NAME, PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] ether_reg, ether_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] port_reg, port_next;
    logic        flags_ok_reg, flags_ok_next;
    logic [15:0] qcount_reg, qcount_next;

    logic        accept;
    logic [3:0]  ihl_eff;
    logic        frame_ok;

    function automatic logic is_private(input logic [31:0] a);
        is_private = (a[31:24] == PRIV_A_PREFIX) || (a[31:20] == PRIV_B_PREFIX)
                  || (a[31:16] == PRIV_C_PREFIX);
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign ihl_eff  = (pos_reg == 6'd0) ? in_data[3:0] : ihl_reg;

    assign frame_ok = (ether_reg == ETHERTYPE_IPV4)
                   && !(is_private(src_reg) && is_private(dst_reg))
                   && (proto_reg == IP_PROTO_UDP) && (port_reg == DNS_PORT)
                   && flags_ok_reg && (qcount_reg == QDCOUNT_ONE);

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        ihl_next      = ihl_reg;
        ether_next    = ether_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        proto_next    = proto_reg;
        port_next     = port_reg;
        flags_ok_next = flags_ok_reg;
        qcount_next   = qcount_reg;
        push          = 1'b0;
        push_entry.kind     = KIND_BYTE;
        push_entry.last     = in_last;
        push_entry.data     = in_data;
        push_entry.src_addr = src_reg;
        push_entry.dst_addr = dst_reg;

        if (accept) begin
            case (phase_reg)
                PH_ETH: begin
                    if (pos_reg == 6'd12) ether_next[15:8] = in_data;
                    if (pos_reg == 6'd13) ether_next[7:0] = in_data;
                    if (pos_reg >= 6'd13) begin
                        phase_next = PH_IP;
                        pos_next   = 6'd0;
                    end else begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
                PH_IP: begin
                    if (pos_reg == 6'd0) ihl_next = in_data[3:0];
                    if (pos_reg == 6'd0 && in_data[3:0] < IHL_MIN) begin
                        phase_next = PH_SKIP;
                    end else begin
                        if (pos_reg == 6'd9) proto_next = in_data;
                        if (pos_reg >= 6'd12 && pos_reg <= 6'd15)
                            src_next = {src_reg[23:0], in_data};
                        if (pos_reg >= 6'd16 && pos_reg <= 6'd19)
                            dst_next = {dst_reg[23:0], in_data};
                        if (({1'b0, pos_reg} + 7'd1) >= {1'b0, ihl_eff, 2'b00}) begin
                            phase_next = PH_UDP;
                            pos_next   = 6'd0;
                        end else begin
                            pos_next = pos_reg + 6'd1;
                        end
                    end
                end
                PH_UDP: begin
                    if (pos_reg == 6'd2) port_next[15:8] = in_data;
                    if (pos_reg == 6'd3) port_next[7:0] = in_data;
                    if (pos_reg >= 6'd7) begin
                        phase_next = PH_DNS;
                        pos_next   = 6'd0;
                    end else begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
                PH_DNS: begin
                    if (pos_reg == 6'd2)
                        flags_ok_next = ((in_data & DNS_FLAGS_MASK) == DNS_FLAGS_WANT);
                    if (pos_reg == 6'd4) qcount_next[15:8] = in_data;
                    if (pos_reg == 6'd5) qcount_next[7:0] = in_data;
                    if (pos_reg >= 6'd11) begin
                        pos_next = 6'd0;
                        if (frame_ok) begin
                            phase_next      = PH_NAME;
                            push            = 1'b1;
                            push_entry.kind = KIND_START;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
                PH_NAME: begin
                    push = 1'b1;
                end
                default: begin
                end
            endcase

            // end of frame: everything back to reset values
            if (in_last) begin
                phase_next    = PH_ETH;
                pos_next      = 6'd0;
                ihl_next      = 4'd0;
                ether_next    = 16'd0;
                src_next      = 32'd0;
                dst_next      = 32'd0;
                proto_next    = 8'd0;
                port_next     = 16'd0;
                flags_ok_next = 1'b0;
                qcount_next   = 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_ETH;
            pos_reg      <= 6'd0;
            ihl_reg      <= 4'd0;
            ether_reg    <= 16'd0;
            src_reg      <= 32'd0;
            dst_reg      <= 32'd0;
            proto_reg    <= 8'd0;
            port_reg     <= 16'd0;
            flags_ok_reg <= 1'b0;
            qcount_reg   <= 16'd0;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            ihl_reg      <= ihl_next;
            ether_reg    <= ether_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            proto_reg    <= proto_next;
            port_reg     <= port_next;
            flags_ok_reg <= flags_ok_next;
            qcount_reg   <= qcount_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/dqns_queue.sv
// ----------------------------------------------------------------------------
// dqns_queue
// four-entry queue between the header parser and the name decoder
// ----------------------------------------------------------------------------
`default_nettype none

module dqns_queue import dqns_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire queue_entry_t push_entry,
    input  wire logic         pop,
    output queue_entry_t      pop_entry,
    output logic              empty,
    output logic              full
);

    localparam int DEPTH = 4;

    queue_entry_t mem [DEPTH];
    logic [1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [2:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign empty     = (count_reg == 3'd0);
    assign full      = (count_reg == 3'(DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 3'd1;
        if (!do_push && do_pop) count_next = count_reg - 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/dqns_name.sv
// ----------------------------------------------------------------------------
// dqns_name
// name decoder: walks the length-prefixed labels and drives the result
// register with characters, dots and the closing request
// ----------------------------------------------------------------------------
`default_nettype none

module dqns_name import dqns_pkg::*; #(
    parameter int MAX_NAME_CHARS = 512
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire queue_entry_t entry,
    input  wire logic         entry_valid,
    output logic              entry_pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        out_char,
    output logic              out_done,
    output logic              out_overflow,
    output logic              out_truncated,
    output logic [31:0]       out_src,
    output logic [31:0]       out_dst
);

    localparam int CW = $clog2(MAX_NAME_CHARS + 1);

    typedef enum logic [1:0] {
        NM_IDLE, NM_LEN, NM_CHARS
    } nm_state_t;

    nm_state_t   state_reg, state_next;
    logic [7:0]  label_reg, label_next;
    logic [CW-1:0] chars_reg, chars_next;

    logic        item;
    logic [7:0]  item_char;
    logic        item_done, item_ovf, item_trunc;

    assign entry_pop = entry_valid && (!out_valid || out_ready);

    always_comb begin
        state_next = state_reg;
        label_next = label_reg;
        chars_next = chars_reg;
        item       = 1'b0;
        item_char  = 8'd0;
        item_done  = 1'b0;
        item_ovf   = 1'b0;
        item_trunc = 1'b0;

        if (entry_pop) begin
            case (entry.kind)
                KIND_START: begin
                    chars_next = '0;
                    state_next = NM_LEN;
                    if (entry.last) begin
                        item       = 1'b1;
                        item_done  = 1'b1;
                        item_trunc = 1'b1;
                    end
                end
                KIND_BYTE: begin
                    if (state_reg == NM_LEN || state_reg == NM_CHARS) begin
                        if (chars_reg >= CW'(MAX_NAME_CHARS)) begin
                            item       = 1'b1;
                            item_done  = 1'b1;
                            item_ovf   = 1'b1;
                            state_next = NM_IDLE;
                        end else if (entry.last) begin
                            item       = 1'b1;
                            item_done  = 1'b1;
                            item_trunc = !(state_reg == NM_LEN && entry.data == 8'd0);
                            state_next = NM_IDLE;
                        end else if (state_reg == NM_LEN) begin
                            if (entry.data == 8'd0) begin
                                item       = 1'b1;
                                item_done  = 1'b1;
                                state_next = NM_IDLE;
                            end else begin
                                label_next = entry.data;
                                if (chars_reg != '0) begin
                                    item       = 1'b1;
                                    item_char  = CHAR_DOT;
                                    chars_next = chars_reg + CW'(1);
                                end
                                state_next = NM_CHARS;
                            end
                        end else begin
                            item       = 1'b1;
                            item_char  = entry.data;
                            chars_next = chars_reg + CW'(1);
                            label_next = label_reg - 8'd1;
                            if (label_reg == 8'd1) state_next = NM_LEN;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (entry.last) state_next = NM_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NM_IDLE;
            label_reg <= 8'd0;
            chars_reg <= '0;
            out_valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            label_reg <= label_next;
            chars_reg <= chars_next;
            if (entry_pop && item) out_valid <= 1'b1;
            else if (out_ready) out_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (entry_pop && item) begin
            out_char      <= item_char;
            out_done      <= item_done;
            out_overflow  <= item_ovf;
            out_truncated <= item_trunc;
            out_src       <= entry.src_addr;
            out_dst       <= entry.dst_addr;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/dns_query_name_sniffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_name_sniffer_tb
// self-checking bench for the dns query name sniffer: ethernet frames go in
// one byte per request, and every name request that comes out is checked
// against a behavioural parser or the frame's stated outcome, kept in step with the accepted input bytes
// ----------------------------------------------------------------------------

module dns_query_name_sniffer_tb;
    import dqns_pkg::*;

    localparam int NAME_LIMIT     = 512;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no request moving
    localparam int HOLD_OFF       = 300;    // long receiver stall, fills the block
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_BYTES    = 120;    // input bytes per random phase, at least

    localparam logic [31:0] ADDR_PUB0 = 32'hC6336407;
    localparam logic [31:0] ADDR_PUB1 = 32'h5DB8D80E;

    // sections of the frame as the parser walks it
    typedef enum logic [2:0] {
        SEC_ETH, SEC_IP, SEC_UDP, SEC_DNS, SEC_LABEL_LEN, SEC_LABEL_CHARS, SEC_IGNORE
    } frame_sec_t;

    // which header field a frame carries away from its wanted value
    typedef enum logic [2:0] {
        OVR_NONE, OVR_ETHER, OVR_IHL, OVR_PROTO, OVR_PORT, OVR_FLAGS, OVR_QDCOUNT
    } hdr_ovr_t;

    typedef enum logic [1:0] {
        NM_SIMPLE, NM_EMPTY, NM_MAXLABEL, NM_LONG
    } qname_kind_t;

    // how the expected requests of a frame are obtained
    typedef enum logic [1:0] {
        W_PREDICT,   // from the parser model
        W_NONE,      // frame dropped, nothing comes out
        W_TRUNC,     // one closing request, truncated
        W_CLEAN      // one closing request, clean
    } outcome_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        done;
        logic        overflow;
        logic        truncated;
        logic [31:0] src;
        logic [31:0] dst;
    } name_result_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        hdr_ovr_t    ovr;
        logic [15:0] ovr_val;
        qname_kind_t qname;
        int          cut;       // frame length in bytes, 0 keeps it whole
        outcome_t    want;
    } frame_spec_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;    // frame_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;            // [7:0] name_char, [39:8] source_address,
                                          // [71:40] dest_address
    logic        m_axis_tlast;            // name_done
    logic [1:0]  m_axis_tuser;            // [0] name_overflow, [1] name_truncated

    dns_query_name_sniffer #(
        .MAX_NAME_CHARS(NAME_LIMIT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // name requests still owed by the block, oldest first
    name_result_t name_q[$];
    logic [7:0]   frame_q[$];
    frame_spec_t  dir_tab[$];
    int           err_count     = 0;
    int           quiet_cycles  = 0;
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           hold_left     = 0;

    // ------------------------------------------------------------------
    // behavioural parser
    // ------------------------------------------------------------------
    frame_sec_t  sec;
    int unsigned sec_pos;        // offset within the current section, saturating
    logic [3:0]  p_ihl;
    logic [15:0] p_ether;
    logic [31:0] p_src;
    logic [31:0] p_dst;
    logic [7:0]  p_proto;
    logic [15:0] p_dport;
    logic        p_flags_ok;
    logic [15:0] p_qdcount;
    logic [7:0]  p_label_left;
    int unsigned p_name_len;

    function automatic void parser_clear();
        sec          = SEC_ETH;
        sec_pos      = 0;
        p_ihl        = '0;
        p_ether      = '0;
        p_src        = '0;
        p_dst        = '0;
        p_proto      = '0;
        p_dport      = '0;
        p_flags_ok   = 1'b0;
        p_qdcount    = '0;
        p_label_left = '0;
        p_name_len   = 0;
    endfunction

    function automatic void bump_pos();
        if (sec_pos < 32'hFFFF) sec_pos++;
    endfunction

    function automatic logic private_ip(input logic [31:0] a);
        return a[31:24] == PRIV_A_PREFIX || a[31:20] == PRIV_B_PREFIX ||
               a[31:16] == PRIV_C_PREFIX;
    endfunction

    function automatic name_result_t name_item(input logic [7:0] ch, input logic done,
                                               input logic ovf, input logic trunc,
                                               input logic [31:0] src, input logic [31:0] dst);
        name_result_t r;
        r.ch        = ch;
        r.done      = done;
        r.overflow  = ovf;
        r.truncated = trunc;
        r.src       = src;
        r.dst       = dst;
        return r;
    endfunction

    // one frame byte through the parser, returns 1 when a name request is due
    function automatic logic parse_byte(input logic [7:0] b, input logic last,
                                        output name_result_t res);
        logic hit;
        logic ok;
        hit = 1'b0;
        res = '0;
        case (sec)
            SEC_ETH: begin
                if (sec_pos == 12) p_ether[15:8] = b;
                if (sec_pos == 13) p_ether[7:0] = b;
                if (sec_pos >= 13) begin
                    sec     = SEC_IP;
                    sec_pos = 0;
                end else bump_pos();
            end
            SEC_IP: begin
                if (sec_pos == 0 && b[3:0] < IHL_MIN) begin
                    sec = SEC_IGNORE;
                end else begin
                    if (sec_pos == 0) p_ihl = b[3:0];
                    if (sec_pos == 9) p_proto = b;
                    if (sec_pos >= 12 && sec_pos <= 15) p_src = {p_src[23:0], b};
                    if (sec_pos >= 16 && sec_pos <= 19) p_dst = {p_dst[23:0], b};
                    if (sec_pos + 1 >= p_ihl * 4) begin
                        sec     = SEC_UDP;
                        sec_pos = 0;
                    end else bump_pos();
                end
            end
            SEC_UDP: begin
                if (sec_pos == 2) p_dport[15:8] = b;
                if (sec_pos == 3) p_dport[7:0] = b;
                if (sec_pos >= 7) begin
                    sec     = SEC_DNS;
                    sec_pos = 0;
                end else bump_pos();
            end
            SEC_DNS: begin
                if (sec_pos == 2) p_flags_ok = (b & DNS_FLAGS_MASK) == DNS_FLAGS_WANT;
                if (sec_pos == 4) p_qdcount[15:8] = b;
                if (sec_pos == 5) p_qdcount[7:0] = b;
                if (sec_pos >= 11) begin
                    ok = p_ether == ETHERTYPE_IPV4 && !(private_ip(p_src) && private_ip(p_dst))
                         && p_proto == IP_PROTO_UDP && p_dport == DNS_PORT
                         && p_flags_ok && p_qdcount == QDCOUNT_ONE;
                    sec_pos    = 0;
                    p_name_len = 0;
                    if (ok) begin
                        sec = SEC_LABEL_LEN;
                        // frame stops right after the dns header
                        if (last) begin
                            res = name_item(8'h00, 1'b1, 1'b0, 1'b1, p_src, p_dst);
                            hit = 1'b1;
                        end
                    end else sec = SEC_IGNORE;
                end else bump_pos();
            end
            SEC_LABEL_LEN, SEC_LABEL_CHARS: begin
                hit = 1'b1;
                if (p_name_len >= NAME_LIMIT) begin
                    res = name_item(8'h00, 1'b1, 1'b1, 1'b0, p_src, p_dst);
                    sec = SEC_IGNORE;
                end else if (last) begin
                    // clean only when the last byte is the terminating zero length
                    res = name_item(8'h00, 1'b1, 1'b0,
                                    !(sec == SEC_LABEL_LEN && b == 8'h00), p_src, p_dst);
                    sec = SEC_IGNORE;
                end else if (sec == SEC_LABEL_LEN) begin
                    if (b == 8'h00) begin
                        res = name_item(8'h00, 1'b1, 1'b0, 1'b0, p_src, p_dst);
                        sec = SEC_IGNORE;
                    end else begin
                        p_label_left = b;
                        if (p_name_len != 0) begin
                            res = name_item(CHAR_DOT, 1'b0, 1'b0, 1'b0, p_src, p_dst);
                            p_name_len++;
                        end else hit = 1'b0;
                        sec = SEC_LABEL_CHARS;
                    end
                end else begin
                    res = name_item(b, 1'b0, 1'b0, 1'b0, p_src, p_dst);
                    p_name_len++;
                    p_label_left = p_label_left - 8'd1;
                    if (p_label_left == 8'd0) sec = SEC_LABEL_LEN;
                end
            end
            default: ;
        endcase
        if (last) parser_clear();
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // frame building
    // ------------------------------------------------------------------
    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    function automatic void add_label(input int len);
        frame_q.push_back(8'(len));
        repeat (len) frame_q.push_back(any_byte());
    endfunction

    function automatic void add_qname(input qname_kind_t k);
        int n;
        case (k)
            NM_SIMPLE: begin
                n = $urandom_range(4, 1);
                repeat (n) begin
                    // now and then a longer label, which may run beyond the usual 63 bytes
                    if ($urandom_range(11) == 0) add_label($urandom_range(80, 13));
                    else add_label($urandom_range(12, 1));
                end
            end
            NM_MAXLABEL: add_label(255);
            NM_LONG: repeat (9) add_label(63);   // runs past the name limit
            default: ;
        endcase
        frame_q.push_back(8'h00);
    endfunction

    function automatic void build_frame(input frame_spec_t f);
        logic [15:0] ether;
        logic [15:0] dport;
        logic [15:0] qd;
        logic [7:0]  proto;
        logic [7:0]  flags;
        logic [3:0]  ihl;
        ether = ETHERTYPE_IPV4;
        dport = DNS_PORT;
        qd    = QDCOUNT_ONE;
        proto = IP_PROTO_UDP;
        flags = DNS_FLAGS_WANT;
        ihl   = IHL_MIN;
        case (f.ovr)
            OVR_ETHER:   ether = f.ovr_val;
            OVR_IHL:     ihl   = f.ovr_val[3:0];
            OVR_PROTO:   proto = f.ovr_val[7:0];
            OVR_PORT:    dport = f.ovr_val;
            OVR_FLAGS:   flags = f.ovr_val[7:0];
            OVR_QDCOUNT: qd    = f.ovr_val;
            default: ;
        endcase
        frame_q.delete();
        // ethernet: two mac addresses then ethertype
        repeat (12) frame_q.push_back(any_byte());
        frame_q.push_back(ether[15:8]);
        frame_q.push_back(ether[7:0]);
        // ipv4 header, options when ihl is above five
        frame_q.push_back({4'h4, ihl});
        repeat (8) frame_q.push_back(any_byte());
        frame_q.push_back(proto);
        repeat (2) frame_q.push_back(any_byte());
        for (int i = 3; i >= 0; i--) frame_q.push_back(f.src[8*i +: 8]);
        for (int i = 3; i >= 0; i--) frame_q.push_back(f.dst[8*i +: 8]);
        if (ihl > IHL_MIN) repeat (int'(ihl) * 4 - 20) frame_q.push_back(any_byte());
        // udp header
        repeat (2) frame_q.push_back(any_byte());
        frame_q.push_back(dport[15:8]);
        frame_q.push_back(dport[7:0]);
        repeat (4) frame_q.push_back(any_byte());
        // dns header
        repeat (2) frame_q.push_back(any_byte());
        frame_q.push_back(flags);
        frame_q.push_back(any_byte());
        frame_q.push_back(qd[15:8]);
        frame_q.push_back(qd[7:0]);
        repeat (6) frame_q.push_back(any_byte());
        add_qname(f.qname);
        repeat (4) frame_q.push_back(any_byte());   // qtype and qclass
        if (f.cut != 0) while (frame_q.size() > f.cut) void'(frame_q.pop_back());
    endfunction

    function automatic void fill_noise();
        frame_q.delete();
        repeat ($urandom_range(60, 1)) frame_q.push_back(any_byte());
    endfunction

    function automatic logic [31:0] rand_addr();
        case ($urandom_range(5))
            0:       return {PRIV_A_PREFIX, 24'($urandom)};
            1:       return {PRIV_B_PREFIX, 20'($urandom)};
            2:       return {PRIV_C_PREFIX, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed queries with random content, the rest bent headers
    function automatic frame_spec_t random_spec();
        frame_spec_t f;
        int r;
        f.src     = rand_addr();
        f.dst     = rand_addr();
        f.ovr     = OVR_NONE;
        f.ovr_val = '0;
        f.qname   = NM_SIMPLE;
        f.cut     = 0;
        f.want    = W_PREDICT;
        r = $urandom_range(99);
        if (r < 10) begin
            f.ovr     = OVR_IHL;
            f.ovr_val = 16'($urandom_range(15, 5));
        end else if (r < 20) begin
            // authoritative bit is not looked at
            f.ovr     = OVR_FLAGS;
            f.ovr_val = {8'h00, DNS_FLAGS_WANT | ~DNS_FLAGS_MASK};
        end else if (r >= 75) begin
            f.ovr     = hdr_ovr_t'($urandom_range(6, 1));
            f.ovr_val = 16'($urandom);
        end
        r = $urandom_range(99);
        if (r < 8) f.qname = NM_EMPTY;
        else if (r < 11) f.qname = NM_MAXLABEL;
        if ($urandom_range(6) == 0) f.cut = $urandom_range(120, 1);
        return f;
    endfunction

    function automatic void add_row(input logic [31:0] src, input logic [31:0] dst,
                                    input hdr_ovr_t ovr, input logic [15:0] val,
                                    input qname_kind_t qname, input int cut,
                                    input outcome_t want);
        frame_spec_t f;
        f.src     = src;
        f.dst     = dst;
        f.ovr     = ovr;
        f.ovr_val = val;
        f.qname   = qname;
        f.cut     = cut;
        f.want    = want;
        dir_tab.push_back(f);
    endfunction

    // ------------------------------------------------------------------
    // input side: one byte per request, random idle gaps before each
    // ------------------------------------------------------------------
    task automatic send_frame(input outcome_t want, input logic [31:0] src,
                              input logic [31:0] dst, output int live);
        name_result_t r;
        logic got;
        logic last;
        live = 0;
        for (int i = 0; i < frame_q.size(); i++) begin
            last = (i == frame_q.size() - 1);
            while ($urandom_range(99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= frame_q[i];
            s_axis_tlast  <= last;
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
            live++;
            got = parse_byte(frame_q[i], last, r);
            if (want == W_PREDICT && got) name_q.push_back(r);
            if (last && (want == W_TRUNC || want == W_CLEAN))
                name_q.push_back(name_item(8'h00, 1'b1, 1'b0, want == W_TRUNC, src, dst));
        end
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", fname, exp_v, got_v);
            err_count++;
        end
    endtask

    // every name request leaving the block is matched to the oldest one owed
    always @(posedge aclk) begin
        name_result_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (name_q.size() == 0) begin
                $error("unexpected name request: char %0h done %0b",
                       m_axis_tdata[7:0], m_axis_tlast);
                err_count++;
            end else begin
                w = name_q.pop_front();
                check_field("name_char",      32'(w.ch),        32'(m_axis_tdata[7:0]));
                check_field("name_done",      32'(w.done),      32'(m_axis_tlast));
                check_field("name_overflow",  32'(w.overflow),  32'(m_axis_tuser[0]));
                check_field("name_truncated", 32'(w.truncated), 32'(m_axis_tuser[1]));
                check_field("source_address", w.src,            m_axis_tdata[39:8]);
                check_field("dest_address",   w.dst,            m_axis_tdata[71:40]);
            end
        end
    end

    // watchdog: too long without a request moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        frame_spec_t f;
        int n;
        int fed;
        parser_clear();

        // directed frames, one header condition at a time
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_NONE, 16'h0000, NM_SIMPLE, 0, W_PREDICT);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_ETHER, 16'h86DD, NM_EMPTY, 0, W_NONE);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_ETHER, 16'hFFFF, NM_EMPTY, 0, W_NONE);
        // both ends private, at the edges of the ranges
        add_row(32'h0A000000, 32'hC0A8FFFF, OVR_NONE, 16'h0000, NM_EMPTY, 0, W_NONE);
        add_row(32'hAC100000, 32'hAC1FFFFF, OVR_NONE, 16'h0000, NM_EMPTY, 0, W_NONE);
        // one end just outside a private range, then both ends public
        add_row(32'hAC200000, 32'h0AFFFFFF, OVR_NONE, 16'h0000, NM_SIMPLE, 0, W_PREDICT);
        add_row(32'hC0A80001, 32'hAC0FFFFF, OVR_NONE, 16'h0000, NM_SIMPLE, 0, W_PREDICT);
        add_row(32'hFFFFFFFF, 32'h00000000, OVR_NONE, 16'h0000, NM_SIMPLE, 0, W_PREDICT);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_PROTO, 16'h0006, NM_EMPTY, 0, W_NONE);
        // short ip header is refused, a full one with options is fine
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_IHL, 16'h0004, NM_EMPTY, 0, W_NONE);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_IHL, 16'h0000, NM_EMPTY, 0, W_NONE);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_IHL, 16'h000F, NM_SIMPLE, 0, W_PREDICT);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_PORT, 16'h3500, NM_EMPTY, 0, W_NONE);
        // response, opcode, truncation, no recursion; authoritative bit ignored
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_FLAGS, 16'h0081, NM_EMPTY, 0, W_NONE);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_FLAGS, 16'h0009, NM_EMPTY, 0, W_NONE);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_FLAGS, 16'h0003, NM_EMPTY, 0, W_NONE);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_FLAGS, 16'h0000, NM_EMPTY, 0, W_NONE);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_FLAGS, 16'h0005, NM_SIMPLE, 0, W_PREDICT);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_QDCOUNT, 16'h0000, NM_EMPTY, 0, W_NONE);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_QDCOUNT, 16'h0101, NM_EMPTY, 0, W_NONE);
        // frame ends with the dns header, at the terminator, inside a label
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_NONE, 16'h0000, NM_SIMPLE, 54, W_TRUNC);
        add_row(ADDR_PUB1, ADDR_PUB0, OVR_NONE, 16'h0000, NM_EMPTY, 55, W_CLEAN);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_NONE, 16'h0000, NM_SIMPLE, 57, W_PREDICT);
        // widest label, name overflow with and without the frame ending there
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_NONE, 16'h0000, NM_MAXLABEL, 0, W_PREDICT);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_NONE, 16'h0000, NM_LONG, 568, W_PREDICT);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_NONE, 16'h0000, NM_LONG, 570, W_PREDICT);
        // frames that end inside the ethernet or ip header
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_NONE, 16'h0000, NM_SIMPLE, 1, W_NONE);
        add_row(ADDR_PUB0, ADDR_PUB1, OVR_NONE, 16'h0000, NM_SIMPLE, 30, W_NONE);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[k]) begin
            build_frame(dir_tab[k]);
            send_frame(dir_tab[k].want, dir_tab[k].src, dir_tab[k].dst, n);
        end

        // random frames: free flow, idle sender, stalling receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            // receiver holds off for a long stretch while bytes keep coming
            if (ph == 0) hold_left = HOLD_OFF;
            fed = 0;
            while (fed < PHASE_BYTES) begin
                if ($urandom_range(99) < 8) begin
                    fill_noise();
                    send_frame(W_PREDICT, '0, '0, n);
                end else begin
                    f = random_spec();
                    build_frame(f);
                    send_frame(f.want, f.src, f.dst, n);
                end
                fed += n;
            end
        end
        s_axis_tvalid <= 1'b0;

        // let the block drain, the watchdog covers a hang here
        while (name_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
